// ----- src/iba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes for the indexed block allocator.
// Used by the controller, the datapath, the top level and the checker.
package iba_pkg;

  // Geometry
  localparam int MAX_BLOCKS      = 64;
  localparam int MAX_FILE_BLOCKS = 10;
  localparam int MAX_FILES       = 16;

  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int GRP_SZ  = 8;
  localparam int NGRP    = MAX_BLOCKS / GRP_SZ;
  localparam int GRP_W   = $clog2(NGRP);
  localparam int BIT_W   = $clog2(GRP_SZ);
  localparam int FCNT_W  = $clog2(MAX_FILES + 1);
  localparam int DB_W    = 7;
  localparam int LEN_W   = 4;
  localparam int SLOT_W  = 4;
  localparam int FILE_W  = 4;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [DB_W-1:0] DISK_BLOCKS_RST = DB_W'(MAX_BLOCKS);

  typedef enum logic [0:0] {
    REG_DISK_BLOCKS = 1'b0
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_SET    = 1'b0,
    OP_CREATE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    ROLE_INDEX = 1'b0,
    ROLE_DATA  = 1'b1
  } role_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_DIR_FULL = 3'd3,
    ST_ZERO_LEN = 3'd4
  } status_t;

  // Input beat
  typedef struct packed {
    op_t              operation;
    logic [BLK_W-1:0] block_index;
    logic             block_free;
    logic [LEN_W-1:0] file_length;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [BLK_W-1:0]  block_number;
    role_t             block_role;
    logic [SLOT_W-1:0] data_slot;
    logic [FILE_W-1:0] file_number;
    status_t           status;
    logic              last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    inc_file;
    logic    latch_grp;
    logic    take_blk;
    logic    emit_final;
    status_t final_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic dir_full;
    logic zero_len;
    logic too_long;
    logic none_free;
    logic last_blk;
  } stat_t;

endpackage

// ----- src/indexed_block_allocator_core.sv -----
`timescale 1ns / 1ps
// Top level of the indexed block allocator: configuration register,
// sequencer and datapath. Depends on iba_pkg, iba_ctrl and iba_dp.
//
//  channel  | handshake                  | beat
//  ---------+----------------------------+--------------------------------
//  in       | in_valid / in_ready        | in_item_t: set or create request
//  out      | out_valid / out_ready      | out_item_t: one block or final status
//  config   | psel/penable/pwrite/pready | disk_blocks at byte address 0
//
// A set beat is taken in the idle state. A create is accepted and checked,
// then each allocated block, for a file of up to ten data blocks plus its
// index block, takes a group-flag step and then a bit-pick step of the
// two-step first-fit search over the 64-bit free map. A stalled output holds
// the search; a waiting final beat does not block the next input beat.
// Reset (rst, synchronous) frees every block, clears the file count and
// sets disk_blocks to 64.
module indexed_block_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  iba_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output iba_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iba_pkg::PADDR_W-1:0]       paddr,
  input  logic [iba_pkg::PDATA_W-1:0]       pwdata,
  output logic [iba_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import iba_pkg::*;

  logic [DB_W-1:0] disk_blocks;
  logic            reg_hit;
  cmd_t            cmd;
  stat_t           stat;

  // Register decode: one word at byte address 0
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_DISK_BLOCKS);
  assign prdata  = reg_hit ? PDATA_W'(disk_blocks) : '0;

  // Hold the scan limit
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= DISK_BLOCKS_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      disk_blocks <= pwdata[DB_W-1:0];
    end
  end

  iba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_item.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_item     (in_item),
    .disk_blocks (disk_blocks),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

// ----- src/iba_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the allocator: checks a create, then steps the first-fit
// search block by block. Depends on iba_pkg.
module iba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  iba_pkg::op_t   in_op,
  output logic           in_ready,
  input  iba_pkg::stat_t stat,
  output iba_pkg::cmd_t  cmd
);
  import iba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FINAL,
    S_GRP,
    S_BIT
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t fin_status;
  status_t fin_status_next;

  // Next state and commands
  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.final_status = fin_status;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_op == OP_CREATE) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.dir_full) begin
          fin_status_next = ST_DIR_FULL;
          state_next      = S_FINAL;
        end else if (stat.zero_len) begin
          fin_status_next = ST_ZERO_LEN;
          state_next      = S_FINAL;
        end else if (stat.too_long) begin
          fin_status_next = ST_TOO_LONG;
          state_next      = S_FINAL;
        end else begin
          cmd.inc_file = 1'b1;
          state_next   = S_GRP;
        end
      end
      S_FINAL: begin
        if (stat.slot_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_GRP: begin
        cmd.latch_grp = 1'b1;
        state_next    = S_BIT;
      end
      S_BIT: begin
        // Hold until the output register can take a beat
        if (stat.slot_free) begin
          if (stat.none_free) begin
            cmd.emit_final   = 1'b1;
            cmd.final_status = ST_NO_SPACE;
            state_next       = S_IDLE;
          end else begin
            cmd.take_blk = 1'b1;
            state_next   = stat.last_blk ? S_IDLE : S_GRP;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered status code
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= ST_OK;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
    end
  end

endmodule

// ----- src/iba_dp.sv -----
`timescale 1ns / 1ps
// Datapath: free-block map, file counter, two-step first-fit search and
// the result register. Depends on iba_pkg.
module iba_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  iba_pkg::cmd_t                     cmd,
  output iba_pkg::stat_t                    stat,
  input  iba_pkg::in_item_t                 in_item,
  input  logic [iba_pkg::DB_W-1:0]          disk_blocks,
  output logic                              out_valid,
  input  logic                              out_ready,
  output iba_pkg::out_item_t                out_item
);
  import iba_pkg::*;

  logic [MAX_BLOCKS-1:0] free_map;
  logic [MAX_BLOCKS-1:0] lim_mask;
  logic [MAX_BLOCKS-1:0] avail;
  logic [NGRP-1:0]       grp_any;
  logic [NGRP-1:0]       grp_any_next;
  logic [FCNT_W-1:0]     file_count;
  logic [FILE_W-1:0]     file_num;
  logic [LEN_W-1:0]      len;
  logic [SLOT_W-1:0]     alloc_idx;
  logic [GRP_W-1:0]      g_sel;
  logic [BIT_W-1:0]      b_sel;
  logic [GRP_SZ-1:0]     grp_bits;
  logic [BLK_W-1:0]      blk;

  // Free blocks that lie below the scan limit
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      lim_mask[i] = (DB_W'(i) < disk_blocks);
    end
    avail = free_map & lim_mask;
  end

  // First step: one flag per group of eight blocks
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_next[g] = |avail[g*GRP_SZ +: GRP_SZ];
    end
  end

  // Second step: lowest flagged group, then lowest free bit in it
  always_comb begin
    g_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) g_sel = GRP_W'(g);
    end
    grp_bits = avail[g_sel*GRP_SZ +: GRP_SZ];
    b_sel = '0;
    for (int b = GRP_SZ - 1; b >= 0; b--) begin
      if (grp_bits[b]) b_sel = BIT_W'(b);
    end
    blk = {g_sel, b_sel};
  end

  // Status toward the controller
  always_comb begin
    stat.slot_free = !out_valid || out_ready;
    stat.dir_full  = (file_count >= FCNT_W'(MAX_FILES));
    stat.zero_len  = (len == '0);
    stat.too_long  = (len > LEN_W'(MAX_FILE_BLOCKS));
    stat.none_free = (grp_any == '0);
    stat.last_blk  = (alloc_idx == SLOT_W'(len));
  end

  // Control state: map, counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map   <= '1;
      file_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept && in_item.operation == OP_SET) begin
        free_map[in_item.block_index] <= in_item.block_free;
      end
      if (cmd.take_blk) begin
        free_map[blk] <= 1'b0;
      end
      if (cmd.inc_file) begin
        file_count <= file_count + FCNT_W'(1);
      end
      if (cmd.take_blk || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.operation == OP_CREATE) begin
      len       <= in_item.file_length;
      file_num  <= file_count[FILE_W-1:0];
      alloc_idx <= '0;
    end
    if (cmd.latch_grp) begin
      grp_any <= grp_any_next;
    end
    if (cmd.take_blk) begin
      alloc_idx             <= alloc_idx + SLOT_W'(1);
      out_item.block_number <= blk;
      out_item.block_role   <= (alloc_idx == '0) ? ROLE_INDEX : ROLE_DATA;
      out_item.data_slot    <= (alloc_idx == '0) ? '0 : alloc_idx - SLOT_W'(1);
      out_item.file_number  <= file_num;
      out_item.status       <= ST_OK;
      out_item.last         <= stat.last_blk;
    end else if (cmd.emit_final) begin
      out_item.block_number <= '0;
      out_item.block_role   <= ROLE_INDEX;
      out_item.data_slot    <= '0;
      out_item.file_number  <= file_num;
      out_item.status       <= cmd.final_status;
      out_item.last         <= 1'b1;
    end
  end

endmodule

// ----- src/iba_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the allocator, bound to the top level.
// Depends on iba_pkg and indexed_block_allocator_core.
module iba_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input iba_pkg::out_item_t out_item
);
  import iba_pkg::*;

  // Come out of reset ready for a beat
  a_ready_after_rst: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // A failing status only on the final beat
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.last)
    else $error("error status on non-final beat");

  // Index block sits at slot zero
  a_index_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.block_role == ROLE_INDEX |-> out_item.data_slot == '0)
    else $error("index block with nonzero slot");

  // A data block is never reported with an error status
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.block_role == ROLE_DATA |-> out_item.status == ST_OK)
    else $error("data block with error status");

endmodule

bind indexed_block_allocator_core iba_checker u_iba_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
